### sv/utf8_stream_validator_unit_assert.svh
// ---------------------------------------------------------------------------
// utf8_stream_validator_unit_assert.svh
// Assertion macros used by the checker of the UTF-8 stream validator.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UTF8_SV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 stream validator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define UTF8_SV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 stream validator assertion failed");

`endif

### sv/utf8_sv_pkg.sv
// ---------------------------------------------------------------------------
// utf8_sv_pkg
// Types and constants of the UTF-8 stream validator.
// ---------------------------------------------------------------------------
package utf8_sv_pkg;

   localparam int COUNT_WIDTH = 25;
   localparam int MAX_BYTES_WIDTH = 24;
   localparam int COMPARE_WIDTH =
      (COUNT_WIDTH > MAX_BYTES_WIDTH) ? COUNT_WIDTH : MAX_BYTES_WIDTH;
   localparam int CODE_WIDTH = 21;

   localparam logic [MAX_BYTES_WIDTH-1:0] MAX_BYTES_RESET = 24'd8388608;

   // Configuration port: one register, byte address 4*index.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_MAX_DOCUMENT_BYTES = 1'b0;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NUL       = 3'd1,
      ST_BAD_BYTE  = 3'd2,
      ST_TRUNC     = 3'd3,
      ST_BAD_CP    = 3'd4,
      ST_TOO_LARGE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_TWO   = 2'd1,
      CLASS_THREE = 2'd2,
      CLASS_FOUR  = 2'd3
   } min_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type status;
      logic       done_res;
   } rsp_payload_type;

   // Per-document decoder state, excluding the byte counter.
   typedef struct packed {
      status_type              error_code;
      logic                    tentative_error;
      logic [1:0]              bytes_still_due;
      logic [CODE_WIDTH-1:0]   code_value;
      min_class_type           minimum_class;
   } doc_state_type;

   function automatic logic [CODE_WIDTH-1:0] class_minimum(min_class_type cls);
      logic [CODE_WIDTH-1:0] result;
      case (cls)
         CLASS_TWO:   result = 21'h00080;
         CLASS_THREE: result = 21'h00800;
         CLASS_FOUR:  result = 21'h10000;
         default:     result = '0;
      endcase
      return result;
   endfunction

endpackage

### sv/utf8_stream_validator_unit.sv
// ---------------------------------------------------------------------------
// utf8_stream_validator_unit
// Streaming UTF-8 document checker reporting the first error per document.
// ---------------------------------------------------------------------------
// Usage: documents arrive one byte per transaction on the req_ channel, the
// final byte of each document flagged by last_byte. Every request produces
// exactly one response transaction on the rsp_ channel carrying the status
// so far; the response to the final byte has done_res set and holds the
// verdict for the whole document. Status is sticky per document, and a
// document longer than max_document_bytes reports too-large over any other
// error.
// Each response is registered in the single output register and is valid in
// the cycle after its byte is taken. One byte is taken per cycle while the
// receiver does not stall. The decoder update is one short combinational step.
// When the receiver stalls, the held response stays stable and req_stall is
// raised only while that register is full and stalled, so the block takes a
// new byte in the same cycle a waiting response is taken.
// pready is always high. Reset clears all document state, empties the output
// register and sets max_document_bytes to 8388608. The user must write the
// register on csr_ with no document in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module utf8_stream_validator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // Byte input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  utf8_sv_pkg::req_payload_type           req_payload,
   // Status output channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output utf8_sv_pkg::rsp_payload_type           rsp_payload,
   // Configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [utf8_sv_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                   csr_pready
);

   logic [utf8_sv_pkg::MAX_BYTES_WIDTH-1:0] max_bytes_ff;
   logic [utf8_sv_pkg::MAX_BYTES_WIDTH-1:0] max_bytes_in;
   logic [utf8_sv_pkg::COUNT_WIDTH-1:0]     byte_count_ff;
   logic [utf8_sv_pkg::COUNT_WIDTH-1:0]     byte_count_in;
   logic [utf8_sv_pkg::COUNT_WIDTH-1:0]     count_step;
   utf8_sv_pkg::doc_state_type              doc_state_ff;
   utf8_sv_pkg::doc_state_type              doc_state_in;
   utf8_sv_pkg::doc_state_type              doc_state_step;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   utf8_sv_pkg::rsp_payload_type            rsp_payload_ff;
   utf8_sv_pkg::rsp_payload_type            rsp_payload_in;
   logic                                    req_take;
   logic                                    csr_write;
   logic                                    too_large;

   // The output register frees up in the same cycle its response is taken.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // Configuration access. Register index is the word address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == utf8_sv_pkg::REG_MAX_DOCUMENT_BYTES) begin
         csr_prdata = utf8_sv_pkg::CSR_DATA_WIDTH'(max_bytes_ff);
      end
   end

   always_comb begin
      max_bytes_in = max_bytes_ff;
      if (csr_write && (csr_paddr[2] == utf8_sv_pkg::REG_MAX_DOCUMENT_BYTES)) begin
         max_bytes_in = csr_pwdata[utf8_sv_pkg::MAX_BYTES_WIDTH-1:0];
      end
   end

   // Saturating document length counter.
   assign count_step = (&byte_count_ff) ? byte_count_ff
                                        : byte_count_ff + utf8_sv_pkg::COUNT_WIDTH'(1);

   utf8_sv_decode u_decode (
      .state_cur (doc_state_ff),
      .data_byte (req_payload.data_byte),
      .last_byte (req_payload.last_byte),
      .state_nxt (doc_state_step)
   );

   // Length check uses the count including the current byte.
   assign too_large = utf8_sv_pkg::COMPARE_WIDTH'(count_step) >
                      utf8_sv_pkg::COMPARE_WIDTH'(max_bytes_ff);

   always_comb begin
      doc_state_in   = doc_state_ff;
      byte_count_in  = byte_count_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      if (req_take) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.status   = too_large ? utf8_sv_pkg::ST_TOO_LARGE
                                             : doc_state_step.error_code;
         rsp_payload_in.done_res = req_payload.last_byte;
         if (req_payload.last_byte) begin
            // End of document: the next byte opens a fresh one.
            doc_state_in  = '0;
            byte_count_in = '0;
         end else begin
            doc_state_in  = doc_state_step;
            byte_count_in = count_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff  <= utf8_sv_pkg::MAX_BYTES_RESET;
         byte_count_ff <= '0;
         doc_state_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_bytes_ff  <= max_bytes_in;
         byte_count_ff <= byte_count_in;
         doc_state_ff  <= doc_state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### sv/utf8_sv_decode.sv
// ---------------------------------------------------------------------------
// utf8_sv_decode
// Next-state logic of the UTF-8 sequence decoder for one byte.
// ---------------------------------------------------------------------------
module utf8_sv_decode (
   input  utf8_sv_pkg::doc_state_type state_cur,
   input  logic [7:0]                 data_byte,
   input  logic                       last_byte,
   output utf8_sv_pkg::doc_state_type state_nxt
);

   logic [utf8_sv_pkg::CODE_WIDTH-1:0] code_cont;
   logic                               tent_cont;
   logic [1:0]                         due_cont;
   logic                               cp_bad;

   assign code_cont = {state_cur.code_value[utf8_sv_pkg::CODE_WIDTH-7:0], data_byte[5:0]};
   assign tent_cont = state_cur.tentative_error | (data_byte[7:6] != 2'b10);
   assign due_cont  = state_cur.bytes_still_due - 2'd1;
   assign cp_bad    = (code_cont < utf8_sv_pkg::class_minimum(state_cur.minimum_class)) ||
                      (code_cont > 21'h10ffff) ||
                      ((code_cont >= 21'h00d800) && (code_cont <= 21'h00dfff));

   always_comb begin
      state_nxt = state_cur;
      if (state_cur.error_code == utf8_sv_pkg::ST_OK) begin
         if (state_cur.bytes_still_due != 2'd0) begin
            // Continuation byte: consumed even when malformed.
            state_nxt.code_value      = code_cont;
            state_nxt.bytes_still_due = due_cont;
            state_nxt.tentative_error = tent_cont;
            if (due_cont == 2'd0) begin
               if (tent_cont) begin
                  state_nxt.error_code = utf8_sv_pkg::ST_BAD_BYTE;
               end else if (cp_bad) begin
                  state_nxt.error_code = utf8_sv_pkg::ST_BAD_CP;
               end
               state_nxt.tentative_error = 1'b0;
            end
         end else begin
            state_nxt.tentative_error = 1'b0;
            if (data_byte == 8'h00) begin
               state_nxt.error_code = utf8_sv_pkg::ST_NUL;
            end else if (data_byte < 8'h80) begin
               // Plain ASCII needs nothing more.
            end else if (data_byte inside {[8'hc2:8'hdf]}) begin
               state_nxt.bytes_still_due = 2'd1;
               state_nxt.code_value      = {16'd0, data_byte[4:0]};
               state_nxt.minimum_class   = utf8_sv_pkg::CLASS_TWO;
            end else if (data_byte inside {[8'he0:8'hef]}) begin
               state_nxt.bytes_still_due = 2'd2;
               state_nxt.code_value      = {17'd0, data_byte[3:0]};
               state_nxt.minimum_class   = utf8_sv_pkg::CLASS_THREE;
            end else if (data_byte inside {[8'hf0:8'hf4]}) begin
               state_nxt.bytes_still_due = 2'd3;
               state_nxt.code_value      = {18'd0, data_byte[2:0]};
               state_nxt.minimum_class   = utf8_sv_pkg::CLASS_FOUR;
            end else begin
               state_nxt.error_code = utf8_sv_pkg::ST_BAD_BYTE;
            end
         end
         // A document that ends mid-sequence is truncated, even over a
         // pending bad continuation.
         if (last_byte && (state_nxt.bytes_still_due != 2'd0) &&
             (state_nxt.error_code == utf8_sv_pkg::ST_OK)) begin
            state_nxt.error_code = utf8_sv_pkg::ST_TRUNC;
         end
      end
   end

endmodule

### sv/utf8_sv_checker.sv
// ---------------------------------------------------------------------------
// utf8_sv_checker
// Port-level assertions for the UTF-8 stream validator, bound to the top.
// ---------------------------------------------------------------------------
`include "utf8_stream_validator_unit_assert.svh"

module utf8_sv_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input utf8_sv_pkg::req_payload_type req_payload,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input utf8_sv_pkg::rsp_payload_type rsp_payload
);

   // A stalled response holds until taken.
   `UTF8_SV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // Every accepted byte yields a response on the next cycle.
   `UTF8_SV_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && !req_stall, rsp_valid)

   // The final byte of a document yields the final verdict.
   `UTF8_SV_ASSERT_NEXT(a_done_follows, clock, reset, req_valid && !req_stall && req_payload.last_byte, rsp_payload.done_res)

   // Input back-pressure only while a response waits on a stalled receiver.
   `UTF8_SV_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Status codes stay within the defined set.
   `UTF8_SV_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_payload.status <= utf8_sv_pkg::ST_TOO_LARGE)

endmodule

bind utf8_stream_validator_unit utf8_sv_checker u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming UTF-8 document validator.
// ----------------------------------------------------------------------------
// Documents are offered one byte per transaction. A predictor in the bench
// tracks the decoder state and works out the status of every byte. The
// checker compares each response with the oldest prediction. The size limit
// register is written only while no transaction is outstanding. Both channels
// idle and stall at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;
   localparam int END_CYCLES = 10;
   localparam int RANDOM_BYTES_PER_ROUND = 25;
   localparam logic [utf8_sv_pkg::CSR_ADDR_WIDTH-1:0] MAX_BYTES_ADDR =
      utf8_sv_pkg::CSR_ADDR_WIDTH'(4 * int'(utf8_sv_pkg::REG_MAX_DOCUMENT_BYTES));

   // Kinds of damage that the document builder can put into a noisy document.
   typedef enum int {
      FAULT_RANDOM_BYTE,
      FAULT_NUL,
      FAULT_TRUNCATED,
      FAULT_OVERLONG,
      FAULT_SURROGATE,
      FAULT_OUT_OF_RANGE,
      FAULT_LONE_CONT,
      FAULT_BAD_CONT
   } fault_kind_type;

   // Every input of the block holds a known value from time zero.
   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   utf8_sv_pkg::req_payload_type           req_payload = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   utf8_sv_pkg::rsp_payload_type           rsp_payload;
   logic                                   csr_psel = 1'b0;
   logic                                   csr_penable = 1'b0;
   logic                                   csr_pwrite = 1'b0;
   logic [utf8_sv_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                   csr_pready;

   // Bench copy of the per-document decoder state and of the size limit.
   utf8_sv_pkg::status_type                 doc_error = utf8_sv_pkg::ST_OK;
   bit                                      cont_bad = 1'b0;
   bit [1:0]                                cont_due = '0;
   bit [utf8_sv_pkg::CODE_WIDTH-1:0]        code_acc = '0;
   utf8_sv_pkg::min_class_type              span_class = utf8_sv_pkg::CLASS_NONE;
   bit [utf8_sv_pkg::COUNT_WIDTH-1:0]       doc_length = '0;
   bit [utf8_sv_pkg::MAX_BYTES_WIDTH-1:0]   max_bytes = utf8_sv_pkg::MAX_BYTES_RESET;

   utf8_sv_pkg::rsp_payload_type pending_status[$];
   bit [7:0]                     doc_bytes[$];

   int  failures = 0;
   int  responses_checked = 0;
   int  bytes_sent = 0;
   int  docs_sent = 0;
   int  limits_used = 0;
   int  verdict_count[8];
   int  cycle_count = 0;
   bit  quiet_sender = 1'b0;
   bit  quiet_receiver = 1'b0;
   int  hold_token = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  run_left = 0;
   bit  run_stall = 1'b0;

   utf8_stream_validator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs a handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d responses outstanding",
                  $time, pending_status.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor. Takes one accepted byte and returns the status the block must
   // report for it. Once an error is committed, bytes are only counted. A
   // continuation byte with the wrong top bits is held back as tentative
   // until the span is complete, so that a document ending inside the span
   // reports truncation rather than a bad byte. The length check is applied
   // last and wins over every other verdict.
   // -------------------------------------------------------------------------
   task automatic predict_status(input utf8_sv_pkg::req_payload_type rq,
                                 output utf8_sv_pkg::rsp_payload_type rs);
      bit [utf8_sv_pkg::CODE_WIDTH-1:0] lowest;
      if (doc_length != '1) begin
         doc_length++;
      end
      if (doc_error == utf8_sv_pkg::ST_OK) begin
         if (cont_due != 2'd0) begin
            if (rq.data_byte[7:6] != 2'b10) begin
               cont_bad = 1'b1;
            end
            code_acc = {code_acc[utf8_sv_pkg::CODE_WIDTH-7:0], rq.data_byte[5:0]};
            cont_due--;
            if (cont_due == 2'd0) begin
               case (span_class)
                  utf8_sv_pkg::CLASS_TWO:   lowest = 21'h00080;
                  utf8_sv_pkg::CLASS_THREE: lowest = 21'h00800;
                  utf8_sv_pkg::CLASS_FOUR:  lowest = 21'h10000;
                  default:                  lowest = '0;
               endcase
               if (cont_bad) begin
                  doc_error = utf8_sv_pkg::ST_BAD_BYTE;
               end else if (code_acc < lowest || code_acc > 21'h10ffff ||
                            (code_acc >= 21'h0d800 && code_acc <= 21'h0dfff)) begin
                  doc_error = utf8_sv_pkg::ST_BAD_CP;
               end
               cont_bad = 1'b0;
            end
         end else begin
            // A new character starts here.
            if (rq.data_byte == 8'h00) begin
               doc_error = utf8_sv_pkg::ST_NUL;
            end else if (rq.data_byte < 8'h80) begin
               // Plain ASCII needs nothing further.
            end else if (rq.data_byte >= 8'hc2 && rq.data_byte <= 8'hdf) begin
               cont_due = 2'd1;
               code_acc = utf8_sv_pkg::CODE_WIDTH'(rq.data_byte[4:0]);
               span_class = utf8_sv_pkg::CLASS_TWO;
            end else if (rq.data_byte >= 8'he0 && rq.data_byte <= 8'hef) begin
               cont_due = 2'd2;
               code_acc = utf8_sv_pkg::CODE_WIDTH'(rq.data_byte[3:0]);
               span_class = utf8_sv_pkg::CLASS_THREE;
            end else if (rq.data_byte >= 8'hf0 && rq.data_byte <= 8'hf4) begin
               cont_due = 2'd3;
               code_acc = utf8_sv_pkg::CODE_WIDTH'(rq.data_byte[2:0]);
               span_class = utf8_sv_pkg::CLASS_FOUR;
            end else begin
               doc_error = utf8_sv_pkg::ST_BAD_BYTE;
            end
            cont_bad = 1'b0;
         end
         if (rq.last_byte && cont_due != 2'd0 && doc_error == utf8_sv_pkg::ST_OK) begin
            doc_error = utf8_sv_pkg::ST_TRUNC;
         end
      end
      rs.status = (doc_length > utf8_sv_pkg::COUNT_WIDTH'(max_bytes)) ?
                  utf8_sv_pkg::ST_TOO_LARGE : doc_error;
      rs.done_res = rq.last_byte;
      // The final byte closes the document; the next byte starts afresh.
      if (rq.last_byte) begin
         doc_error = utf8_sv_pkg::ST_OK;
         cont_bad = 1'b0;
         cont_due = '0;
         code_acc = '0;
         span_class = utf8_sv_pkg::CLASS_NONE;
         doc_length = '0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Monitor and checker. Both channels are sampled at the rising edge, so the
   // values seen are those that the handshake at that edge used. Predictions
   // are queued before responses are taken off, which keeps the order right
   // whatever the latency of the block.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      utf8_sv_pkg::rsp_payload_type predicted;
      utf8_sv_pkg::rsp_payload_type oldest;
      utf8_sv_pkg::rsp_payload_type got;
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            predict_status(req_payload, predicted);
            pending_status.push_back(predicted);
            if (predicted.done_res) begin
               verdict_count[predicted.status]++;
            end
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = rsp_payload;
            responses_checked++;
            if (pending_status.size() == 0) begin
               $display("%0t: response with no transaction outstanding, %s %0d done %0b",
                        $time, "expected none, got status", got.status, got.done_res);
               failures++;
            end else begin
               oldest = pending_status.pop_front();
               if (got.status !== oldest.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, oldest.status, got.status);
                  failures++;
               end
               if (got.done_res !== oldest.done_res) begin
                  $display("%0t: done_res mismatch, expected %0b, got %0b",
                           $time, oldest.done_res, got.done_res);
                  failures++;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. Runs of stall and no stall of random length, mostly short with
   // the odd long one. A change of hold_token asks for one long hold-off,
   // which this process counts down on its own.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_receiver) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  run_stall = 1'b0;
                  run_left = $urandom_range(1, 8);
               end else if (pick < 62) begin
                  run_stall = 1'b0;
                  run_left = $urandom_range(20, 60);
               end else if (pick < 94) begin
                  run_stall = 1'b1;
                  run_left = $urandom_range(1, 3);
               end else begin
                  run_stall = 1'b1;
                  run_left = $urandom_range(10, 30);
               end
            end
            run_left--;
            rsp_stall <= run_stall;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender. Offers one byte, after a random gap unless the sender is told to
   // stay busy, and returns at the edge at which the transaction is taken.
   // Valid is left high so that the next byte can follow back to back.
   // -------------------------------------------------------------------------
   task automatic offer_byte(input bit [7:0] value, input bit last);
      int gap;
      int pick;
      gap = 0;
      if (!quiet_sender) begin
         pick = $urandom_range(0, 99);
         if (pick >= 97) begin
            gap = $urandom_range(8, 25);
         end else if (pick >= 60) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{data_byte: value, last_byte: last};
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic send_document();
      for (int i = 0; i < doc_bytes.size(); i++) begin
         offer_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      end
      docs_sent++;
   endtask

   // Drops valid and waits until every predicted response has come back. As the
   // block gives one response per byte, it is then idle.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Document builder.
   // -------------------------------------------------------------------------
   task automatic put_code(input bit [utf8_sv_pkg::CODE_WIDTH-1:0] cp, input int n);
      bit [utf8_sv_pkg::CODE_WIDTH-1:0] part;
      case (n)
         1:       doc_bytes.push_back(cp[7:0]);
         2:       doc_bytes.push_back({3'b110, cp[10:6]});
         3:       doc_bytes.push_back({4'b1110, cp[15:12]});
         default: doc_bytes.push_back({5'b11110, cp[20:18]});
      endcase
      for (int k = n - 2; k >= 0; k--) begin
         part = cp >> (6 * k);
         doc_bytes.push_back({2'b10, part[5:0]});
      end
   endtask

   // Appends a well-formed character of at least min_len bytes.
   task automatic add_valid_char(input int min_len, output int n);
      bit [utf8_sv_pkg::CODE_WIDTH-1:0] cp;
      n = $urandom_range(min_len, 4);
      case (n)
         1: cp = utf8_sv_pkg::CODE_WIDTH'($urandom_range(1, 'h7f));
         2: cp = utf8_sv_pkg::CODE_WIDTH'($urandom_range('h80, 'h7ff));
         3: begin
            cp = utf8_sv_pkg::CODE_WIDTH'($urandom_range('h800, 'hffff));
            // Move surrogates out of the way by flipping one high bit.
            if (cp >= 21'h0d800 && cp <= 21'h0dfff) begin
               cp ^= 21'h04000;
            end
         end
         default: cp = utf8_sv_pkg::CODE_WIDTH'($urandom_range('h10000, 'h10ffff));
      endcase
      put_code(cp, n);
   endtask

   // A clean document holds only well-formed characters. In a noisy one about
   // a quarter of the characters are damaged in one of several ways.
   task automatic build_document(input int chars, input bit noisy);
      int             n;
      int             idx;
      bit [7:0]       v;
      fault_kind_type kind;
      doc_bytes.delete();
      for (int c = 0; c < chars; c++) begin
         if (!noisy || $urandom_range(0, 3) != 0) begin
            add_valid_char(1, n);
         end else begin
            kind = fault_kind_type'($urandom_range(0, 7));
            case (kind)
               FAULT_RANDOM_BYTE: doc_bytes.push_back(8'($urandom_range(0, 255)));
               FAULT_NUL:         doc_bytes.push_back(8'h00);
               FAULT_TRUNCATED: begin
                  add_valid_char(2, n);
                  repeat ($urandom_range(1, n - 1)) void'(doc_bytes.pop_back());
               end
               FAULT_OVERLONG: begin
                  n = $urandom_range(2, 4);
                  put_code(utf8_sv_pkg::CODE_WIDTH'((n == 2) ? $urandom_range(0, 'h7f) :
                                                    (n == 3) ? $urandom_range(0, 'h7ff) :
                                                               $urandom_range(0, 'hffff)),
                           n);
               end
               FAULT_SURROGATE:
                  put_code(utf8_sv_pkg::CODE_WIDTH'($urandom_range('hd800, 'hdfff)), 3);
               FAULT_OUT_OF_RANGE:
                  put_code(utf8_sv_pkg::CODE_WIDTH'($urandom_range('h110000, 'h1fffff)), 4);
               FAULT_LONE_CONT:
                  doc_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
               default: begin
                  // Spoil one continuation byte of an otherwise good character.
                  add_valid_char(2, n);
                  idx = doc_bytes.size() - 1 - int'($urandom_range(0, n - 2));
                  v = 8'($urandom_range(0, 255));
                  if (v[7:6] == 2'b10) begin
                     v[7] = 1'b0;
                  end
                  doc_bytes[idx] = v;
               end
            endcase
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Configuration port. Setup cycle, then access cycle until pready. Read
   // data is taken at the falling edge inside the access cycle.
   // -------------------------------------------------------------------------
   task automatic csr_access(input bit write,
                             input bit [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] wdata,
                             output bit [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= MAX_BYTES_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_max_bytes_readback();
      bit [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] rdata;
      csr_access(1'b0, '0, rdata);
      if (rdata !== utf8_sv_pkg::CSR_DATA_WIDTH'(max_bytes)) begin
         $display("%0t: max_document_bytes readback, expected %0d, got %0d",
                  $time, max_bytes, rdata);
         failures++;
      end
   endtask

   // The limit changes only between documents, with nothing outstanding.
   task automatic set_max_bytes(input bit [utf8_sv_pkg::MAX_BYTES_WIDTH-1:0] value);
      bit [utf8_sv_pkg::CSR_DATA_WIDTH-1:0] unused;
      wait_all_responses();
      csr_access(1'b1, utf8_sv_pkg::CSR_DATA_WIDTH'(value), unused);
      max_bytes = value;
      limits_used++;
      check_max_bytes_readback();
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // Reset value, then both extremes of the register.
   task automatic test_register_access();
      check_max_bytes_readback();
      set_max_bytes(24'hffffff);
      set_max_bytes(24'h000000);
      set_max_bytes(utf8_sv_pkg::MAX_BYTES_RESET);
   endtask

   // One short document for each rule of the decoder.
   task automatic test_directed_sequences();
      doc_bytes = '{8'h7f, 8'h41};                 send_document(); // clean ASCII
      doc_bytes = '{8'h00};                        send_document(); // NUL byte
      doc_bytes = '{8'h80};                        send_document(); // stray continuation
      doc_bytes = '{8'hff, 8'hc1};                 send_document(); // bad lead, then only counted
      doc_bytes = '{8'hf5};                        send_document(); // first lead past the range
      doc_bytes = '{8'hc2, 8'h41};                 send_document(); // bad continuation at span end
      doc_bytes = '{8'he2, 8'h41};                 send_document(); // truncation over tentative
      doc_bytes = '{8'hc3, 8'h00};                 send_document(); // NUL inside a span
      doc_bytes = '{8'he0, 8'h80, 8'h80};          send_document(); // overlong
      doc_bytes = '{8'hed, 8'ha0, 8'h80};          send_document(); // surrogate
      doc_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};   send_document(); // beyond U+10FFFF
      doc_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};   send_document(); // highest valid code point
   endtask

   // Too-large verdicts under a zero and a tiny limit, and none under the largest one.
   task automatic test_size_limit();
      set_max_bytes(24'd0);
      repeat (3) begin
         build_document($urandom_range(1, 3), 1'($urandom_range(0, 1)));
         send_document();
      end
      set_max_bytes(24'd4);
      repeat (8) begin
         build_document($urandom_range(1, 6), 1'($urandom_range(0, 1)));
         send_document();
      end
      set_max_bytes(24'hffffff);
      repeat (3) begin
         build_document($urandom_range(2, 8), 1'b1);
         send_document();
      end
   endtask

   // Bulk of the stimulus: mostly well-formed documents with random content,
   // under four limits. Now and then a long document crosses a small limit.
   task automatic test_random_documents();
      bit [utf8_sv_pkg::MAX_BYTES_WIDTH-1:0] limits[4];
      int                                    round_start;
      limits[0] = utf8_sv_pkg::MAX_BYTES_RESET;
      limits[1] = utf8_sv_pkg::MAX_BYTES_WIDTH'($urandom_range(8, 30));
      limits[2] = 24'hffffff;
      limits[3] = utf8_sv_pkg::MAX_BYTES_WIDTH'($urandom_range(1, 12));
      foreach (limits[r]) begin
         set_max_bytes(limits[r]);
         round_start = bytes_sent;
         while (bytes_sent - round_start < RANDOM_BYTES_PER_ROUND) begin
            build_document(($urandom_range(0, 11) == 0) ? $urandom_range(15, 40) :
                                                          $urandom_range(1, 8),
                           $urandom_range(0, 9) < 4);
            send_document();
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering bytes, so the output register fills and req_stall rises.
   // Afterwards the sender pauses until every response has arrived.
   task automatic test_receiver_hold();
      wait_all_responses();
      quiet_sender = 1'b1;
      hold_token <= hold_token + 1;
      build_document(20, 1'b0);
      send_document();
      quiet_sender = 1'b0;
      wait_all_responses();
   endtask

   // A stretch with no idling on either side.
   task automatic test_unbroken_stream();
      quiet_sender = 1'b1;
      quiet_receiver <= 1'b1;
      repeat (4) begin
         build_document($urandom_range(5, 12), 1'($urandom_range(0, 1)));
         send_document();
      end
      quiet_sender = 1'b0;
      quiet_receiver <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_sequences();
      test_size_limit();
      test_random_documents();
      test_receiver_hold();
      test_unbroken_stream();

      // Let the last responses through, then stay idle to catch anything the
      // block might still put out.
      wait_all_responses();
      repeat (END_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_status.size());
         failures++;
      end

      $display("Covered %0d documents, %0d bytes, %0d responses under %0d size limits.",
               docs_sent, bytes_sent, responses_checked, limits_used);
      $display("Verdicts: ok %0d, nul %0d, bad byte %0d, truncated %0d, %s %0d, too large %0d.",
               verdict_count[utf8_sv_pkg::ST_OK], verdict_count[utf8_sv_pkg::ST_NUL],
               verdict_count[utf8_sv_pkg::ST_BAD_BYTE], verdict_count[utf8_sv_pkg::ST_TRUNC],
               "bad code point", verdict_count[utf8_sv_pkg::ST_BAD_CP],
               verdict_count[utf8_sv_pkg::ST_TOO_LARGE]);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### utf8_stream_validator_unit.f
+incdir+sv
sv/utf8_sv_pkg.sv
sv/utf8_sv_decode.sv
sv/utf8_stream_validator_unit.sv
sv/utf8_sv_checker.sv
tb/tb_top.sv
